>>> src/charger_register_command_encoder_defines.svh
// Assertion macros shared by the charger command encoder RTL.
// Included by every module that carries concurrent checks.
`ifndef CHARGER_REGISTER_COMMAND_ENCODER_DEFINES_SVH
`define CHARGER_REGISTER_COMMAND_ENCODER_DEFINES_SVH

`ifndef SYNTH
`define CHG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");
`define CHG_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");
`else
`define CHG_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CHG_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> src/chgcmd_pkg.sv
// Types and constants for the charger command encoder.
// Used by chgcmd_div and charger_register_command_encoder; no dependencies.
`timescale 1ns / 1ps

package chgcmd_pkg;

   // shared divider
   localparam int DIV_W     = 24;
   localparam int DVS_W     = 7;
   localparam int DIV_ITERS = DIV_W / 2;
   localparam int CNT_W     = $clog2(DIV_ITERS + 1);

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quot;
      logic [DVS_W-1:0] rem;
   } div_rsp_type;

   // sequencer
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_VMUL,
      ST_VDIV1,
      ST_VDIV2,
      ST_CMUL1,
      ST_CMUL2,
      ST_CDIV,
      ST_AMUL1,
      ST_AMUL2,
      ST_DONE
   } state_type;

   // command codes
   localparam logic [4:0] CMD_CTRL0_INIT = 5'd0;
   localparam logic [4:0] CMD_CTRL1_INIT = 5'd1;
   localparam logic [4:0] CMD_CTRL2_INIT = 5'd2;
   localparam logic [4:0] CMD_CTRL3_INIT = 5'd3;
   localparam logic [4:0] CMD_CTRL4_INIT = 5'd4;
   localparam logic [4:0] CMD_MAX_SYS    = 5'd5;
   localparam logic [4:0] CMD_MIN_SYS    = 5'd6;
   localparam logic [4:0] CMD_OTG_EN     = 5'd7;
   localparam logic [4:0] CMD_OTG_VOLT   = 5'd8;
   localparam logic [4:0] CMD_OTG_CUR    = 5'd9;
   localparam logic [4:0] CMD_RD_INFO1   = 5'd10;
   localparam logic [4:0] CMD_RD_INFO2   = 5'd11;
   localparam logic [4:0] CMD_SET_ADP    = 5'd12;
   localparam logic [4:0] CMD_IN_VOLT    = 5'd13;
   localparam logic [4:0] CMD_ADP_INIT   = 5'd14;
   localparam logic [4:0] CMD_CHG_INIT   = 5'd15;
   localparam logic [4:0] CMD_SET_CHG    = 5'd16;
   localparam logic [4:0] CMD_LOAD_EN    = 5'd17;
   localparam logic [4:0] CMD_LOAD_DIS   = 5'd18;
   localparam logic [4:0] CMD_VSYS_CTRL  = 5'd19;

   // charger register command bytes
   localparam logic [7:0] REG_CHG_LIM  = 8'h14;
   localparam logic [7:0] REG_MAX_SYS  = 8'h15;
   localparam logic [7:0] REG_CTRL0    = 8'h39;
   localparam logic [7:0] REG_INFO1    = 8'h3A;
   localparam logic [7:0] REG_CTRL1    = 8'h3C;
   localparam logic [7:0] REG_CTRL2    = 8'h3D;
   localparam logic [7:0] REG_MIN_SYS  = 8'h3E;
   localparam logic [7:0] REG_ADP_LIM  = 8'h3F;
   localparam logic [7:0] REG_OTG_VOLT = 8'h49;
   localparam logic [7:0] REG_OTG_CUR  = 8'h4A;
   localparam logic [7:0] REG_IN_VOLT  = 8'h4B;
   localparam logic [7:0] REG_CTRL3    = 8'h4C;
   localparam logic [7:0] REG_INFO2    = 8'h4D;
   localparam logic [7:0] REG_CTRL4    = 8'h4E;

   // fixed words
   localparam logic [15:0] WORD_CTRL0    = 16'h0003;
   localparam logic [15:0] WORD_LOAD_DIS = 16'h0002;
   localparam logic [15:0] WORD_CTRL1    = 16'h0004;
   localparam logic [15:0] WORD_CTRL2    = 16'h2800;
   localparam logic [15:0] WORD_CTRL3    = 16'h8081;
   localparam logic [15:0] WORD_OTG_EN   = 16'h0804;
   localparam logic [15:0] WORD_IN_VOLT  = 16'h0B00;

   // arithmetic constants
   localparam logic [DVS_W-1:0] PCT_DIV      = 7'd100;
   localparam logic [DVS_W-1:0] VOLT_STEP    = 7'd12;
   localparam logic [DVS_W-1:0] VOLT_HALF    = 7'd6;
   localparam logic [7:0]       CUR_SCALE    = 8'd10;
   localparam logic [7:0]       FIXED_MARGIN = 8'd120;
   localparam logic [9:0]       CUR_HALF     = 10'd512;
   localparam logic [9:0]       ADP_FLOOR    = 10'd100;

   // configuration register indexes
   localparam logic [2:0] CSR_OTG_GAIN   = 3'd0;
   localparam logic [2:0] CSR_OTG_OFFSET = 3'd1;
   localparam logic [2:0] CSR_MAX_SYS    = 3'd2;
   localparam logic [2:0] CSR_MIN_SYS    = 3'd3;
   localparam logic [2:0] CSR_CHG_LIM    = 3'd4;

   localparam logic [7:0]  RST_OTG_GAIN   = 8'd102;
   localparam logic [15:0] RST_OTG_OFFSET = 16'd0;
   localparam logic [14:0] RST_MAX_SYS    = 15'd12000;
   localparam logic [13:0] RST_MIN_SYS    = 14'd9000;
   localparam logic [15:0] RST_CHG_LIM    = 16'd2000;

endpackage

>>> src/chgcmd_div.sv
// Shared radix-4 restoring divider, two quotient bits per cycle.
// Depends on chgcmd_pkg for widths and the request/response structs.
`timescale 1ns / 1ps
`include "charger_register_command_encoder_defines.svh"

module chgcmd_div (
   input  logic                     clock,
   input  logic                     reset,
   input  chgcmd_pkg::div_req_type  div_req,
   output chgcmd_pkg::div_rsp_type  div_rsp
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [chgcmd_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [chgcmd_pkg::DIV_W-1:0]       quot_ff, quot_in;
   logic [chgcmd_pkg::DVS_W-1:0]       rem_ff, rem_in;
   logic [chgcmd_pkg::DVS_W-1:0]       dvs_ff, dvs_in;

   logic [chgcmd_pkg::DVS_W:0]         r1, r2, r1s, r2s;
   logic                               ge1, ge2;

   // two dependent subtract steps per cycle
   always_comb begin
      r1  = {rem_ff, quot_ff[chgcmd_pkg::DIV_W-1]};
      ge1 = (r1 >= {1'b0, dvs_ff});
      r1s = ge1 ? (r1 - {1'b0, dvs_ff}) : r1;
      r2  = {r1s[chgcmd_pkg::DVS_W-1:0], quot_ff[chgcmd_pkg::DIV_W-2]};
      ge2 = (r2 >= {1'b0, dvs_ff});
      r2s = ge2 ? (r2 - {1'b0, dvs_ff}) : r2;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = chgcmd_pkg::CNT_W'(chgcmd_pkg::DIV_ITERS);
         quot_in = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[chgcmd_pkg::DIV_W-3:0], ge1, ge2};
         rem_in  = r2s[chgcmd_pkg::DVS_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == chgcmd_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;
   assign div_rsp.rem  = rem_ff;

   `CHG_ASSERT_IMP(a_no_restart, clock, reset, div_req.start, !busy_ff)
   `CHG_ASSERT_NXT(a_start_busy, clock, reset, div_req.start, busy_ff)
   `CHG_ASSERT_IMP(a_busy_cnt, clock, reset, busy_ff, cnt_ff != '0)

endmodule

>>> src/charger_register_command_encoder.sv
// Charger command encoder top level: sequencer, shared multiplier, output word.
// Depends on chgcmd_pkg and chgcmd_div.
`timescale 1ns / 1ps
`include "charger_register_command_encoder_defines.svh"

// Usage
//  Request channel (req_*): one command word per accepted valid/stall handshake.
//  Result channel (rsp_*): one register access word per command: command byte,
//  16-bit data and read flag.
//  csr_* writes the five settings; write only while the block is idle.
//  Path from accept to rsp_valid: fixed commands go straight to ST_DONE; OTG
//  current with PPS passes ST_CMUL1, the adapter limit ST_AMUL1 and ST_AMUL2,
//  OTG current on a fixed supply ST_CMUL1, ST_CMUL2 and a division, and OTG
//  voltage ST_VMUL and two divisions, by 100 and by 12. Divisions use the
//  shared divider, which retires two quotient bits a cycle.
//  req_stall is high from acceptance until the result is in the output
//  register; a new command may be taken while that result still waits.
//  If rsp_stall holds the output, a finished second result waits in the
//  sequencer and req_stall stays high.
//  Reset (synchronous) restores the setting defaults, clears the latched
//  adapter current and drops rsp_valid.
module charger_register_command_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [4:0]  req_cmd,
   input  logic [15:0] req_volt_mv,
   input  logic [9:0]  req_cur,
   input  logic        req_pps_mode,
   input  logic        req_non_pd,
   input  logic [9:0]  req_rdo_oper_cur,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_reg_addr,
   output logic [15:0] rsp_data_word,
   output logic        rsp_is_read,
   input  logic        csr_we,
   input  logic [2:0]  csr_idx,
   input  logic [15:0] csr_wdata
);

   chgcmd_pkg::state_type state_ff, state_in;

   logic [7:0]  gain_ff;
   logic [15:0] offset_ff;
   logic [14:0] max_sys_ff;
   logic [13:0] min_sys_ff;
   logic [15:0] chg_lim_ff;
   logic [9:0]  last_req_cur_ff, last_req_cur_in;

   logic [4:0]  cmd_ff;
   logic [15:0] volt_ff;
   logic [9:0]  cur_ff;
   logic        pps_ff;
   logic        nonpd_ff;
   logic [9:0]  opr_ff;

   logic [chgcmd_pkg::DIV_W-1:0] acc_ff, acc_in;
   logic [chgcmd_pkg::DVS_W-1:0] rem_ff, rem_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_addr_ff;
   logic [15:0] rsp_data_ff;
   logic        rsp_rd_ff;

   logic        req_acc;
   logic        out_free;
   logic        load_rsp;

   logic [15:0] mul_a;
   logic [7:0]  mul_b;
   logic [23:0] prod;
   logic [15:0] adp_t;

   logic [7:0]  res_addr;
   logic [15:0] res_data;
   logic        res_rd;
   logic [5:0]  min_hi;
   logic [12:0] volt_steps;
   logic [8:0]  cur_steps;

   chgcmd_pkg::div_req_type div_req;
   chgcmd_pkg::div_rsp_type div_rsp;

   chgcmd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall = (state_ff != chgcmd_pkg::ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // adapter current less the 1 A floor, clamped at zero
   assign adp_t = (acc_ff[15:0] > {6'b0, chgcmd_pkg::ADP_FLOOR})
                  ? (acc_ff[15:0] - {6'b0, chgcmd_pkg::ADP_FLOOR}) : '0;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         chgcmd_pkg::ST_VMUL: begin
            mul_a = volt_ff;
            mul_b = gain_ff;
         end
         chgcmd_pkg::ST_CMUL1: begin
            mul_a = {6'b0, cur_ff};
            mul_b = chgcmd_pkg::CUR_SCALE;
         end
         chgcmd_pkg::ST_CMUL2: begin
            mul_a = acc_ff[15:0];
            mul_b = chgcmd_pkg::FIXED_MARGIN;
         end
         chgcmd_pkg::ST_AMUL1: begin
            mul_a = {6'b0, opr_ff};
            mul_b = chgcmd_pkg::CUR_SCALE;
         end
         chgcmd_pkg::ST_AMUL2: begin
            mul_a = adp_t;
            mul_b = chgcmd_pkg::CUR_SCALE;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // sequencer
   always_comb begin
      state_in        = state_ff;
      acc_in          = acc_ff;
      rem_in          = rem_ff;
      last_req_cur_in = last_req_cur_ff;
      div_req         = '0;
      load_rsp        = 1'b0;
      unique case (state_ff)
         chgcmd_pkg::ST_IDLE: begin
            if (req_acc) begin
               priority case (req_cmd)
                  chgcmd_pkg::CMD_OTG_VOLT: state_in = chgcmd_pkg::ST_VMUL;
                  chgcmd_pkg::CMD_OTG_CUR:  state_in = chgcmd_pkg::ST_CMUL1;
                  chgcmd_pkg::CMD_SET_ADP: begin
                     state_in        = chgcmd_pkg::ST_AMUL1;
                     last_req_cur_in = req_cur;
                  end
                  default: state_in = chgcmd_pkg::ST_DONE;
               endcase
            end
         end
         chgcmd_pkg::ST_VMUL: begin
            div_req.start    = 1'b1;
            div_req.dividend = prod;
            div_req.divisor  = chgcmd_pkg::PCT_DIV;
            state_in         = chgcmd_pkg::ST_VDIV1;
         end
         chgcmd_pkg::ST_VDIV1: begin
            if (div_rsp.done) begin
               div_req.start    = 1'b1;
               div_req.dividend = div_rsp.quot + {8'b0, offset_ff};
               div_req.divisor  = chgcmd_pkg::VOLT_STEP;
               state_in         = chgcmd_pkg::ST_VDIV2;
            end
         end
         chgcmd_pkg::ST_VDIV2: begin
            if (div_rsp.done) begin
               acc_in   = div_rsp.quot;
               rem_in   = div_rsp.rem;
               state_in = chgcmd_pkg::ST_DONE;
            end
         end
         chgcmd_pkg::ST_CMUL1: begin
            acc_in   = prod;
            state_in = pps_ff ? chgcmd_pkg::ST_DONE : chgcmd_pkg::ST_CMUL2;
         end
         chgcmd_pkg::ST_CMUL2: begin
            div_req.start    = 1'b1;
            div_req.dividend = prod;
            div_req.divisor  = chgcmd_pkg::PCT_DIV;
            state_in         = chgcmd_pkg::ST_CDIV;
         end
         chgcmd_pkg::ST_CDIV: begin
            if (div_rsp.done) begin
               acc_in   = div_rsp.quot;
               state_in = chgcmd_pkg::ST_DONE;
            end
         end
         chgcmd_pkg::ST_AMUL1: begin
            acc_in   = nonpd_ff ? {14'b0, cur_ff} : prod;
            state_in = chgcmd_pkg::ST_AMUL2;
         end
         chgcmd_pkg::ST_AMUL2: begin
            acc_in   = prod;
            state_in = chgcmd_pkg::ST_DONE;
         end
         chgcmd_pkg::ST_DONE: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = chgcmd_pkg::ST_IDLE;
            end
         end
         default: state_in = chgcmd_pkg::ST_IDLE;
      endcase
   end

   // result word
   assign min_hi     = min_sys_ff[13:8] + {5'b0, |min_sys_ff[7:0]};
   assign volt_steps = acc_ff[12:0] + {12'b0, (rem_ff > chgcmd_pkg::VOLT_HALF)};
   assign cur_steps  = acc_ff[18:10] + {8'b0, (acc_ff[9:0] > chgcmd_pkg::CUR_HALF)};

   always_comb begin
      res_addr = '0;
      res_data = '0;
      res_rd   = 1'b0;
      unique case (cmd_ff)
         chgcmd_pkg::CMD_CTRL0_INIT,
         chgcmd_pkg::CMD_LOAD_EN: begin
            res_addr = chgcmd_pkg::REG_CTRL0;
            res_data = chgcmd_pkg::WORD_CTRL0;
         end
         chgcmd_pkg::CMD_LOAD_DIS: begin
            res_addr = chgcmd_pkg::REG_CTRL0;
            res_data = chgcmd_pkg::WORD_LOAD_DIS;
         end
         chgcmd_pkg::CMD_CTRL1_INIT: begin
            res_addr = chgcmd_pkg::REG_CTRL1;
            res_data = chgcmd_pkg::WORD_CTRL1;
         end
         chgcmd_pkg::CMD_CTRL2_INIT: begin
            res_addr = chgcmd_pkg::REG_CTRL2;
            res_data = chgcmd_pkg::WORD_CTRL2;
         end
         chgcmd_pkg::CMD_CTRL3_INIT: begin
            res_addr = chgcmd_pkg::REG_CTRL3;
            res_data = chgcmd_pkg::WORD_CTRL3;
         end
         chgcmd_pkg::CMD_CTRL4_INIT: res_addr = chgcmd_pkg::REG_CTRL4;
         chgcmd_pkg::CMD_MAX_SYS: begin
            res_addr = chgcmd_pkg::REG_MAX_SYS;
            res_data = {1'b0, max_sys_ff[14:3], 3'b0};
         end
         chgcmd_pkg::CMD_MIN_SYS: begin
            res_addr = chgcmd_pkg::REG_MIN_SYS;
            res_data = {2'b0, min_hi, 8'b0};
         end
         chgcmd_pkg::CMD_OTG_EN: begin
            res_addr = chgcmd_pkg::REG_CTRL1;
            res_data = chgcmd_pkg::WORD_OTG_EN;
         end
         chgcmd_pkg::CMD_OTG_VOLT: begin
            res_addr = chgcmd_pkg::REG_OTG_VOLT;
            res_data = {volt_steps, 3'b0};
         end
         chgcmd_pkg::CMD_OTG_CUR: begin
            res_addr = chgcmd_pkg::REG_OTG_CUR;
            res_data = {cur_steps, 7'b0};
         end
         chgcmd_pkg::CMD_RD_INFO1: begin
            res_addr = chgcmd_pkg::REG_INFO1;
            res_rd   = 1'b1;
         end
         chgcmd_pkg::CMD_RD_INFO2: begin
            res_addr = chgcmd_pkg::REG_INFO2;
            res_rd   = 1'b1;
         end
         chgcmd_pkg::CMD_SET_ADP: begin
            res_addr = chgcmd_pkg::REG_ADP_LIM;
            // (t * 10 / 32) << 2
            res_data = (cur_ff > chgcmd_pkg::ADP_FLOOR) ? {acc_ff[18:5], 2'b0} : '0;
         end
         chgcmd_pkg::CMD_IN_VOLT: begin
            res_addr = chgcmd_pkg::REG_IN_VOLT;
            res_data = chgcmd_pkg::WORD_IN_VOLT;
         end
         chgcmd_pkg::CMD_ADP_INIT: res_addr = chgcmd_pkg::REG_ADP_LIM;
         chgcmd_pkg::CMD_CHG_INIT: res_addr = chgcmd_pkg::REG_CHG_LIM;
         chgcmd_pkg::CMD_SET_CHG: begin
            res_addr = chgcmd_pkg::REG_CHG_LIM;
            res_data = (last_req_cur_ff == '0) ? '0 : chg_lim_ff;
         end
         chgcmd_pkg::CMD_VSYS_CTRL: begin
            res_addr = chgcmd_pkg::REG_CTRL1;
            res_data = (cur_ff == '0) ? chgcmd_pkg::WORD_CTRL1 : '0;
         end
         default: begin
            res_addr = '0;
            res_data = '0;
            res_rd   = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp)
         rsp_valid_in = 1'b1;
      else if (!rsp_stall)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= chgcmd_pkg::ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         last_req_cur_ff <= '0;
         gain_ff         <= chgcmd_pkg::RST_OTG_GAIN;
         offset_ff       <= chgcmd_pkg::RST_OTG_OFFSET;
         max_sys_ff      <= chgcmd_pkg::RST_MAX_SYS;
         min_sys_ff      <= chgcmd_pkg::RST_MIN_SYS;
         chg_lim_ff      <= chgcmd_pkg::RST_CHG_LIM;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         last_req_cur_ff <= last_req_cur_in;
         if (csr_we) begin
            priority case (csr_idx)
               chgcmd_pkg::CSR_OTG_GAIN:   gain_ff    <= csr_wdata[7:0];
               chgcmd_pkg::CSR_OTG_OFFSET: offset_ff  <= csr_wdata;
               chgcmd_pkg::CSR_MAX_SYS:    max_sys_ff <= csr_wdata[14:0];
               chgcmd_pkg::CSR_MIN_SYS:    min_sys_ff <= csr_wdata[13:0];
               chgcmd_pkg::CSR_CHG_LIM:    chg_lim_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      if (req_acc) begin
         cmd_ff   <= req_cmd;
         volt_ff  <= req_volt_mv;
         cur_ff   <= req_cur;
         pps_ff   <= req_pps_mode;
         nonpd_ff <= req_non_pd;
         opr_ff   <= req_rdo_oper_cur;
      end
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      if (load_rsp) begin
         rsp_addr_ff <= res_addr;
         rsp_data_ff <= res_data;
         rsp_rd_ff   <= res_rd;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_reg_addr  = rsp_addr_ff;
   assign rsp_data_word = rsp_data_ff;
   assign rsp_is_read   = rsp_rd_ff;

   `CHG_ASSERT_NXT(a_busy_after_acc, clock, reset, req_acc, state_ff != chgcmd_pkg::ST_IDLE)
   `CHG_ASSERT_IMP(a_div_done_state, clock, reset, div_rsp.done, state_ff == chgcmd_pkg::ST_VDIV1 || state_ff == chgcmd_pkg::ST_VDIV2 || state_ff == chgcmd_pkg::ST_CDIV)
   `CHG_ASSERT_NXT(a_load_idle, clock, reset, state_ff == chgcmd_pkg::ST_DONE && out_free, rsp_valid_ff && state_ff == chgcmd_pkg::ST_IDLE)
   `CHG_ASSERT_NXT(a_adp_latch, clock, reset, req_acc && req_cmd == chgcmd_pkg::CMD_SET_ADP, last_req_cur_ff == $past(req_cur))

endmodule
